### rtl/core/irt_pkg.sv
`timescale 1ns / 1ps

package irt_pkg;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  localparam int unsigned FIELD_WIDTH = 32;

endpackage

### rtl/core/irt_match.sv
`timescale 1ns / 1ps

module irt_match #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic [TIME_WIDTH-1:0] ent_start_i,
  input  logic [TIME_WIDTH-1:0] ent_end_i,
  input  logic [TIME_WIDTH-1:0] req_start_i,
  input  logic [TIME_WIDTH-1:0] req_end_i,
  output logic                  meet_o
);

  logic req_in_ent;
  logic ent_in_req;

  // half-open intervals, unsigned compares
  assign req_in_ent = (ent_start_i <= req_start_i) && (req_start_i < ent_end_i);
  assign ent_in_req = (req_start_i <= ent_start_i) && (ent_start_i < req_end_i);
  assign meet_o     = req_in_ent || ent_in_req;

endmodule

### rtl/core/interval_reservation_table_top.sv
`timescale 1ns / 1ps

// channel  signals                          direction  payload
// in       in_valid_i / in_ready_o          in         req_start_i, req_end_i
// out      out_valid_o / out_ready_i        out        accepted_o, status_o
//
// each item sweeps the single read port of the interval store once, one entry a
// cycle, then the done state decides and appends an accepted request.
// reset clears the entry count and control state; the store itself is not cleared.
// a result waiting in the output register stalls only the decision cycle.
module interval_reservation_table_top #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [irt_pkg::FIELD_WIDTH-1:0]     req_start_i,
  input  logic [irt_pkg::FIELD_WIDTH-1:0]     req_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                accepted_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EW = 2 * irt_pkg::FIELD_WIDTH + TIME_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         rd_idx_q, rd_idx_d;
  logic                  rvld_q;
  logic                  hit_q, hit_d;
  logic [TIME_WIDTH-1:0] req_a_q, req_b_q;
  logic [TIME_WIDTH-1:0] a_in, b_in;
  logic [EW-1:0]         a_ext, b_ext;

  logic [2*TIME_WIDTH-1:0] mem [CAPACITY];
  logic [2*TIME_WIDTH-1:0] rdata_q;

  logic                  issue;
  logic                  meet;
  logic                  out_free;
  logic                  full;
  logic                  wr_en;
  logic                  in_fire;

  logic                  out_valid_q;
  logic                  accepted_q;
  irt_pkg::status_e      status_q;

  // fields are cut to the time width, or zero-extended above 32 bits
  assign a_ext = {{TIME_WIDTH{1'b0}}, {irt_pkg::FIELD_WIDTH{1'b0}}, req_start_i};
  assign b_ext = {{TIME_WIDTH{1'b0}}, {irt_pkg::FIELD_WIDTH{1'b0}}, req_end_i};
  assign a_in  = a_ext[TIME_WIDTH-1:0];
  assign b_in  = b_ext[TIME_WIDTH-1:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = (state_q == S_SCAN) && (rd_idx_q < count_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = (count_q == CW'(CAPACITY));
  assign wr_en      = (state_q == S_DONE) && out_free && !hit_q && !full;

  irt_match #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_match (
    .ent_start_i (rdata_q[2*TIME_WIDTH-1:TIME_WIDTH]),
    .ent_end_i   (rdata_q[TIME_WIDTH-1:0]),
    .req_start_i (req_a_q),
    .req_end_i   (req_b_q),
    .meet_o      (meet)
  );

  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    hit_d    = hit_q;
    count_d  = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          rd_idx_d = '0;
          hit_d    = 1'b0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (rvld_q && meet) begin
          hit_d = 1'b1;
        end
        // nothing left to issue, the last read is compared this cycle
        if (!issue) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (wr_en) begin
            count_d = count_q + CW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      rvld_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      rvld_q   <= issue;
      hit_q    <= hit_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_a_q <= a_in;
      req_b_q <= b_in;
    end
    if (state_q == S_DONE && out_free) begin
      accepted_q <= !hit_q && !full;
      if (hit_q) begin
        status_q <= irt_pkg::ST_OVERLAP;
      end else if (full) begin
        status_q <= irt_pkg::ST_FULL;
      end else begin
        status_q <= irt_pkg::ST_ACCEPT;
      end
    end
  end

  // interval store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= {req_a_q, req_b_q};
    end
    if (issue) begin
      rdata_q <= mem[rd_idx_q[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign status_o    = status_q;

endmodule

### sim/irt_booking_checker.sv
`timescale 1ns / 1ps

module irt_booking_checker #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [irt_pkg::FIELD_WIDTH-1:0] req_start_i,
  input  logic [irt_pkg::FIELD_WIDTH-1:0] req_end_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            accepted_i,
  input  logic [1:0]                      status_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int unsigned FW = irt_pkg::FIELD_WIDTH;
  localparam int unsigned MASK_BITS = (TIME_WIDTH < FW) ? TIME_WIDTH : FW;
  localparam logic [FW-1:0] TIME_MASK = {FW{1'b1}} >> (FW - MASK_BITS);

  typedef struct packed {
    logic             accepted;
    irt_pkg::status_e status;
  } verdict_t;

  logic [FW-1:0] booked_starts [CAPACITY];
  logic [FW-1:0] booked_ends   [CAPACITY];
  int unsigned   booked_count;
  verdict_t      verdicts [$];

  // half-open intervals, unsigned compare
  function automatic bit intervals_clash(input logic [FW-1:0] s, e, a, b);
    return ((s <= a) && (a < e)) || ((a <= s) && (s < b));
  endfunction

  function automatic verdict_t book_interval(input logic [FW-1:0] start_raw,
                                             input logic [FW-1:0] end_raw);
    logic [FW-1:0] a;
    logic [FW-1:0] b;
    verdict_t      v;
    bit            clash;
    a     = start_raw & TIME_MASK;
    b     = end_raw & TIME_MASK;
    clash = 1'b0;
    for (int unsigned i = 0; i < booked_count; i++) begin
      if (intervals_clash(booked_starts[i], booked_ends[i], a, b)) begin
        clash = 1'b1;
      end
    end
    // overlap wins over a full table
    if (clash) begin
      v = '{accepted: 1'b0, status: irt_pkg::ST_OVERLAP};
    end else if (booked_count >= CAPACITY) begin
      v = '{accepted: 1'b0, status: irt_pkg::ST_FULL};
    end else begin
      booked_starts[booked_count] = a;
      booked_ends[booked_count]   = b;
      booked_count++;
      v = '{accepted: 1'b1, status: irt_pkg::ST_ACCEPT};
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      booked_count = 0;
      verdicts.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i === 1'b1 && in_ready_i === 1'b1) begin
        verdicts.push_back(book_interval(req_start_i, req_end_i));
      end
      if (out_valid_i === 1'b1 && out_ready_i === 1'b1) begin
        if (verdicts.size() == 0) begin
          $error("result with no request outstanding: accepted %0d status %0d",
                 accepted_i, status_i);
          fail_count_o++;
        end else begin
          want = verdicts.pop_front();
          if (accepted_i !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, accepted_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
        end
      end
      pending_o = verdicts.size();
    end
  end

endmodule

### sim/tb_interval_reservation_table_top.sv
`timescale 1ns / 1ps

module tb_interval_reservation_table_top;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned TIME_WIDTH   = 32;
  localparam int unsigned FW           = irt_pkg::FIELD_WIDTH;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef enum int unsigned {
    K_NEIGHBOUR,
    K_FRESH,
    K_BACKWARD,
    K_CORNER,
    K_WILD
  } req_kind_e;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  logic [FW-1:0] req_start = '0;
  logic [FW-1:0] req_end   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          accepted;
  logic [1:0]    status;

  int unsigned   fail_count;
  int unsigned   pending;
  int unsigned   sender_idle_pct = 0;
  int unsigned   stall_pct       = 0;
  int unsigned   hold_left       = 0;
  logic          hold_toggle     = 1'b0;
  logic          hold_seen       = 1'b0;
  int unsigned   cycle_count     = 0;

  logic [FW-1:0] sent_starts [$];
  logic [FW-1:0] sent_ends   [$];

  always #5 clk = ~clk;

  interval_reservation_table_top #(
    .CAPACITY   (CAPACITY),
    .TIME_WIDTH (TIME_WIDTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_start_i (req_start),
    .req_end_i   (req_end),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .accepted_o  (accepted),
    .status_o    (status)
  );

  irt_booking_checker #(
    .CAPACITY   (CAPACITY),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .req_start_i  (req_start),
    .req_end_i    (req_end),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .accepted_i   (accepted),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random stalls, or a long hold-off when the stimulus flips hold_toggle
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic offer(input logic [FW-1:0] a, input logic [FW-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_start <= a;
    req_end   <= b;
    sent_starts.push_back(a);
    sent_ends.push_back(b);
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // many requests are built around earlier boundaries so touching and one-off overlaps are common
  task automatic pick_request(input bit late, output logic [FW-1:0] a, output logic [FW-1:0] b);
    req_kind_e     kind;
    int unsigned   roll;
    int unsigned   k;
    logic [FW-1:0] lo;
    logic [FW-1:0] hi;
    logic [FW-1:0] len;
    logic [FW-1:0] tmp;
    roll = $urandom_range(99);
    kind = (roll < 40) ? K_NEIGHBOUR :
           (roll < 70) ? K_FRESH :
           (roll < 80) ? K_BACKWARD :
           (roll < 90) ? K_CORNER :
           (late ? K_WILD : K_FRESH);
    k   = $urandom_range(sent_starts.size() - 1);
    lo  = sent_starts[k];
    hi  = sent_ends[k];
    len = $urandom_range(64, 1);
    case (kind)
      K_NEIGHBOUR: begin
        case ($urandom_range(3))
          0: begin a = hi; b = hi + len; end
          1: begin b = lo; a = lo - len; end
          2: begin a = lo + $urandom_range(3); b = a + len; end
          default: begin a = hi - 1; b = hi + len; end
        endcase
      end
      K_FRESH: begin
        a = $urandom;
        b = a + $urandom_range(256, 1);
      end
      K_BACKWARD: begin
        // empty or inverted request
        a = $urandom_range(1) ? lo : FW'($urandom);
        b = a - $urandom_range(100);
      end
      K_CORNER: begin
        case ($urandom_range(3))
          0: a = '0;
          1: a = 1;
          2: a = {FW{1'b1}} - 1;
          default: a = {FW{1'b1}};
        endcase
        b = a + $urandom_range(8) - 4;
        if ($urandom_range(1)) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
      end
      default: begin
        a = $urandom;
        b = $urandom;
      end
    endcase
  endtask

  initial begin : stimulus
    logic [FW-1:0] a;
    logic [FW-1:0] b;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(32'd10, 32'd20);
    offer(32'd20, 32'd30);
    offer(32'd5, 32'd10);
    offer(32'd15, 32'd16);
    offer(32'd19, 32'd21);
    offer(32'h0000_0000, 32'hFFFF_FFFF);
    offer(32'd30, 32'd30);
    offer(32'd30, 32'd31);
    offer(32'd25, 32'd12);
    offer(32'd40, 32'd35);
    offer(32'd36, 32'd40);
    offer(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h0000_0000);
    offer(32'd0, 32'd1);
    offer(32'd0, 32'd0);
    offer(32'd1, 32'd5);
    offer(32'h8000_0000, 32'h7FFF_FFFF);
    offer(32'h5555_5555, 32'hAAAA_AAAA);
    offer(32'hAAAA_AAAA, 32'h5555_5555);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case (n / PHASE_ITEMS)
          0: begin
            sender_idle_pct = 0;
            stall_pct      <= 0;
          end
          1: begin
            sender_idle_pct = 67;
            stall_pct      <= 0;
          end
          2: begin
            // let everything come back, then starve the output while items keep coming
            wait_drained();
            sender_idle_pct = 0;
            stall_pct      <= 67;
            hold_toggle    <= ~hold_toggle;
          end
          3: begin
            sender_idle_pct = 11;
            stall_pct      <= 11;
          end
          default: begin
            sender_idle_pct = 0;
            stall_pct      <= 0;
          end
        endcase
      end
      pick_request(n >= 250, a, b);
      offer(a, b);
    end

    wait_drained();
    repeat (CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
